/* hdl/rgc_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package rgc_pkg;

  // Blend weight that selects the foreground color outright
  localparam logic [7:0] GradFullScale = 8'd255;

  // Reciprocal of the full scale for the blend divide; exact for products below 2^14
  localparam int unsigned BlendShift = 22;
  localparam int unsigned BlendRecip =
      ((1 << BlendShift) + int'(GradFullScale) - 1) / int'(GradFullScale);

  localparam int unsigned PaddrWidth = 4;

  typedef enum logic [1:0] {
    REG_FG_COLOR     = 2'd0,
    REG_BG_COLOR     = 2'd1,
    REG_IMAGE_WIDTH  = 2'd2,
    REG_IMAGE_HEIGHT = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    logic [7:0] run_length;
    logic [7:0] intensity;
  } in_item_t;

  typedef struct packed {
    logic [15:0] pixel_color;
    logic [7:0]  run_count;
    logic        last_run;
    logic        overrun;
  } out_item_t;

  typedef struct packed {
    logic [7:0] run_count;
    logic       last_run;
    logic       overrun;
  } run_info_t;

endpackage

`default_nettype wire

/* hdl/rgc_blend.sv */
`timescale 1ns / 1ps
`default_nettype none

module rgc_blend import rgc_pkg::*; (
  input  logic [15:0] fg_color_i,
  input  logic [15:0] bg_color_i,
  input  logic [7:0]  intensity_i,
  output logic [15:0] pixel_color_o
);

  // bg + (fg - bg) * k / full scale, quotient truncated toward zero.
  // Divide by the full scale as a reciprocal multiply and shift.
  function automatic logic [5:0] blend_comp(logic [5:0] f, logic [5:0] b, logic [7:0] k);
    logic signed [6:0] diff;
    logic [6:0]        neg_diff;
    logic [5:0]        mag;
    logic [13:0]       prod;
    logic [36:0]       scaled;
    logic [5:0]        quo;
    diff     = signed'({1'b0, f}) - signed'({1'b0, b});
    neg_diff = 7'(-diff);
    mag      = diff[6] ? neg_diff[5:0] : diff[5:0];
    prod     = 14'(mag * k);
    scaled   = 37'(prod) * 37'(BlendRecip);
    quo      = 6'(scaled >> BlendShift);
    return diff[6] ? 6'(b - quo) : 6'(b + quo);
  endfunction

  logic [15:0] fg_rgb;
  logic [15:0] bg_rgb;
  logic [7:0]  weight;
  logic [5:0]  red;
  logic [5:0]  green;
  logic [5:0]  blue;
  logic [15:0] packed_rgb;

  assign fg_rgb = {fg_color_i[7:0], fg_color_i[15:8]};
  assign bg_rgb = {bg_color_i[7:0], bg_color_i[15:8]};
  assign weight = (intensity_i > GradFullScale) ? GradFullScale : intensity_i;

  assign red   = blend_comp({1'b0, fg_rgb[15:11]}, {1'b0, bg_rgb[15:11]}, weight);
  assign green = blend_comp(fg_rgb[10:5], bg_rgb[10:5], weight);
  assign blue  = blend_comp({1'b0, fg_rgb[4:0]}, {1'b0, bg_rgb[4:0]}, weight);

  assign packed_rgb    = {red[4:0], green, blue[4:0]};
  assign pixel_color_o = {packed_rgb[7:0], packed_rgb[15:8]};

endmodule

`default_nettype wire

/* hdl/rgc_run_ctr.sv */
`timescale 1ns / 1ps
`default_nettype none

module rgc_run_ctr import rgc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic [7:0] image_width_i,
  input  logic [7:0] image_height_i,
  input  logic       reload_i,
  input  logic       step_i,
  input  logic [7:0] run_length_i,
  output run_info_t  info_o
);

  logic [15:0] pixels_left_q;
  logic [15:0] pixels_left_d;
  logic [7:0]  width_eff;
  logic [7:0]  height_eff;
  logic [15:0] image_size;
  logic [15:0] left_after;
  logic [7:0]  count;
  logic        over;

  // Zero dimension counts as one
  assign width_eff  = (image_width_i == 8'd0) ? 8'd1 : image_width_i;
  assign height_eff = (image_height_i == 8'd0) ? 8'd1 : image_height_i;
  assign image_size = 16'(width_eff * height_eff);

  always_comb begin
    over  = 16'(run_length_i) > pixels_left_q;
    count = over ? pixels_left_q[7:0] : run_length_i;
  end

  assign left_after = pixels_left_q - 16'(count);

  always_comb begin
    pixels_left_d = pixels_left_q;
    priority if (reload_i) begin
      pixels_left_d = image_size;
    end else if (step_i) begin
      // Reload at end of image
      pixels_left_d = (left_after == 16'd0) ? image_size : left_after;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pixels_left_q <= 16'd1;
    end else begin
      pixels_left_q <= pixels_left_d;
    end
  end

  assign info_o.run_count = count;
  assign info_o.last_run  = (left_after == 16'd0);
  assign info_o.overrun   = over;

endmodule

`default_nettype wire

/* hdl/rle_gradient_run_colorizer.sv */
`timescale 1ns / 1ps
`default_nettype none

// Run-length gradient colorizer. Each request carries a run length and an
// intensity; the block blends the foreground and background colors (byte-swapped
// RGB565) by intensity / 255 per component, clamps the run to the pixels left in
// the width-by-height image and flags the run that ends the image or overruns it.
// One request is taken every cycle while the output is not stalled; each request
// passes an input register, then the blend and pixel count logic into the output
// register, where its result is presented. The pixel counter reloads when the image
// ends and in the cycle after a width or height write. Write registers only while
// no request is in flight.
module rle_gradient_run_colorizer import rgc_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [PaddrWidth-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  in_item_t              in_item_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output out_item_t             out_item_o
);

  logic [15:0] fg_color_q;
  logic [15:0] bg_color_q;
  logic [7:0]  image_width_q;
  logic [7:0]  image_height_q;
  logic        reload_q;
  logic        reload_d;
  logic        cfg_write;
  cfg_reg_e    cfg_sel;

  logic        in_valid_q;
  in_item_t    in_item_q;
  logic        out_valid_q;
  out_item_t   out_item_q;
  out_item_t   out_item_d;
  logic        out_adv;
  logic        in_take;

  logic [15:0] pixel_color;
  run_info_t   run_info;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;
  assign cfg_sel   = cfg_reg_e'(paddr[3:2]);
  assign reload_d  = cfg_write &&
                     (cfg_sel == REG_IMAGE_WIDTH || cfg_sel == REG_IMAGE_HEIGHT);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fg_color_q     <= 16'd0;
      bg_color_q     <= 16'd0;
      image_width_q  <= 8'd1;
      image_height_q <= 8'd1;
      reload_q       <= 1'b0;
    end else begin
      reload_q <= reload_d;
      if (cfg_write) begin
        unique case (cfg_sel)
          REG_FG_COLOR:     fg_color_q     <= pwdata[15:0];
          REG_BG_COLOR:     bg_color_q     <= pwdata[15:0];
          REG_IMAGE_WIDTH:  image_width_q  <= pwdata[7:0];
          REG_IMAGE_HEIGHT: image_height_q <= pwdata[7:0];
        endcase
      end
    end
  end

  always_comb begin
    unique case (cfg_sel)
      REG_FG_COLOR:     prdata = {16'd0, fg_color_q};
      REG_BG_COLOR:     prdata = {16'd0, bg_color_q};
      REG_IMAGE_WIDTH:  prdata = {24'd0, image_width_q};
      REG_IMAGE_HEIGHT: prdata = {24'd0, image_height_q};
    endcase
  end

  // Advance the output register when a request is held and it is empty or being drained
  assign out_adv    = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !out_adv;
  assign in_take    = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_take) begin
        in_valid_q <= 1'b1;
      end else if (out_adv) begin
        in_valid_q <= 1'b0;
      end
      if (out_adv) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_item_q <= in_item_i;
    end
    if (out_adv) begin
      out_item_q <= out_item_d;
    end
  end

  rgc_blend u_blend (
    .fg_color_i    (fg_color_q),
    .bg_color_i    (bg_color_q),
    .intensity_i   (in_item_q.intensity),
    .pixel_color_o (pixel_color)
  );

  rgc_run_ctr u_run_ctr (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .image_width_i  (image_width_q),
    .image_height_i (image_height_q),
    .reload_i       (reload_q),
    .step_i         (out_adv),
    .run_length_i   (in_item_q.run_length),
    .info_o         (run_info)
  );

  always_comb begin
    out_item_d.pixel_color = pixel_color;
    out_item_d.run_count   = run_info.run_count;
    out_item_d.last_run    = run_info.last_run;
    out_item_d.overrun     = run_info.overrun;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

`default_nettype wire

/* verif/testbench.sv */
`timescale 1ns / 1ps

module testbench;
  import rgc_pkg::*;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [PaddrWidth-1:0] paddr;
  logic [31:0]           pwdata;
  logic [31:0]           prdata;
  logic                  pready;
  logic                  in_valid_i;
  logic                  in_stall_o;
  in_item_t              in_item_i;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  out_item_t             out_item_o;

  rle_gradient_run_colorizer u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Shadow copy of the register file and the pixel counter
  logic [15:0] fg_shadow;
  logic [15:0] bg_shadow;
  logic [7:0]  width_shadow;
  logic [7:0]  height_shadow;
  logic [15:0] pixels_left_shadow;

  out_item_t pending_pixels[$];
  int        n_errors = 0;
  bit        quiet = 1'b0;
  int        hold_requests = 0;
  int        hold_served = 0;
  int        hold_cycles = 0;

  function automatic logic [15:0] frame_pixels();
    logic [15:0] w;
    logic [15:0] h;
    w = (width_shadow == 8'd0) ? 16'd1 : {8'd0, width_shadow};
    h = (height_shadow == 8'd0) ? 16'd1 : {8'd0, height_shadow};
    return w * h;
  endfunction

  function automatic int mix_component(int fc, int bc, int k);
    return (fc - bc) * k / int'(GradFullScale) + bc;
  endfunction

  // Blend the colors for one run and advance the pixel counter
  function automatic out_item_t blend_run(in_item_t rq);
    logic [15:0] f;
    logic [15:0] b;
    logic [15:0] pix;
    int          k;
    int          r;
    int          g;
    int          bl;
    logic [15:0] cnt;
    out_item_t   res;
    f = {fg_shadow[7:0], fg_shadow[15:8]};
    b = {bg_shadow[7:0], bg_shadow[15:8]};
    k = int'(rq.intensity);
    if (k > int'(GradFullScale)) k = int'(GradFullScale);
    r  = mix_component(int'(f[15:11]), int'(b[15:11]), k);
    g  = mix_component(int'(f[10:5]), int'(b[10:5]), k);
    bl = mix_component(int'(f[4:0]), int'(b[4:0]), k);
    pix = {r[4:0], g[5:0], bl[4:0]};
    cnt = {8'd0, rq.run_length};
    res.overrun = 1'b0;
    if (cnt > pixels_left_shadow) begin
      cnt = pixels_left_shadow;
      res.overrun = 1'b1;
    end
    pixels_left_shadow = pixels_left_shadow - cnt;
    res.last_run = 1'b0;
    if (pixels_left_shadow == 16'd0) begin
      res.last_run = 1'b1;
      pixels_left_shadow = frame_pixels();
    end
    res.pixel_color = {pix[7:0], pix[15:8]};
    res.run_count = cnt[7:0];
    return res;
  endfunction

  // Check results first, then record accepted requests and register writes
  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t exp_px;
    if (!rst_ni) begin
      fg_shadow = 16'd0;
      bg_shadow = 16'd0;
      width_shadow = 8'd1;
      height_shadow = 8'd1;
      pixels_left_shadow = 16'd1;
      pending_pixels.delete();
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (pending_pixels.size() == 0) begin
          $error("result with no pending request: %p", out_item_o);
          n_errors++;
        end else begin
          exp_px = pending_pixels.pop_front();
          if (out_item_o.pixel_color !== exp_px.pixel_color) begin
            $error("pixel_color expected %h actual %h", exp_px.pixel_color,
                   out_item_o.pixel_color);
            n_errors++;
          end
          if (out_item_o.run_count !== exp_px.run_count) begin
            $error("run_count expected %0d actual %0d", exp_px.run_count,
                   out_item_o.run_count);
            n_errors++;
          end
          if (out_item_o.last_run !== exp_px.last_run) begin
            $error("last_run expected %b actual %b", exp_px.last_run, out_item_o.last_run);
            n_errors++;
          end
          if (out_item_o.overrun !== exp_px.overrun) begin
            $error("overrun expected %b actual %b", exp_px.overrun, out_item_o.overrun);
            n_errors++;
          end
        end
      end
      if (in_valid_i && !in_stall_o) pending_pixels.push_back(blend_run(in_item_i));
      if (psel && penable && pwrite && pready) begin
        case (cfg_reg_e'(paddr[3:2]))
          REG_FG_COLOR:     fg_shadow = pwdata[15:0];
          REG_BG_COLOR:     bg_shadow = pwdata[15:0];
          REG_IMAGE_WIDTH: begin
            width_shadow = pwdata[7:0];
            pixels_left_shadow = frame_pixels();
          end
          REG_IMAGE_HEIGHT: begin
            height_shadow = pwdata[7:0];
            pixels_left_shadow = frame_pixels();
          end
          default: ;
        endcase
      end
    end
  end

  // Receiver: random stalls, plus long hold-offs on request
  always @(negedge clk_i) begin
    if (hold_cycles > 0) begin
      out_stall_i <= 1'b1;
      hold_cycles <= hold_cycles - 1;
    end else if (hold_requests != hold_served) begin
      out_stall_i <= 1'b1;
      hold_cycles <= 80;
      hold_served <= hold_served + 1;
    end else begin
      out_stall_i <= !quiet && ($urandom_range(99) < 12);
    end
  end

  // All tasks start and end just after a falling edge
  task automatic send_run(input in_item_t rq);
    if (!quiet && $urandom_range(99) < 12) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    in_item_i = rq;
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
  endtask

  task automatic send_pair(input logic [7:0] run, input logic [7:0] k);
    in_item_t rq;
    rq.run_length = run;
    rq.intensity = k;
    send_run(rq);
  endtask

  task automatic wait_drain();
    in_valid_i = 1'b0;
    while (pending_pixels.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic cfg_write(input cfg_reg_e idx, input logic [31:0] val);
    logic [31:0] junk;
    junk = $urandom;
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = {idx, 2'b00};
    // upper bits are don't-care; randomize them
    pwdata = (idx == REG_FG_COLOR || idx == REG_BG_COLOR) ? {junk[31:16], val[15:0]}
                                                           : {junk[31:8], val[7:0]};
    @(negedge clk_i);
    penable = 1'b1;
    @(negedge clk_i);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    // let the pixel counter reload
    repeat (3) @(negedge clk_i);
  endtask

  task automatic set_image(input logic [15:0] fg, input logic [15:0] bg,
                           input logic [7:0] w, input logic [7:0] h);
    wait_drain();
    cfg_write(REG_FG_COLOR, {16'd0, fg});
    cfg_write(REG_BG_COLOR, {16'd0, bg});
    cfg_write(REG_IMAGE_WIDTH, {24'd0, w});
    cfg_write(REG_IMAGE_HEIGHT, {24'd0, h});
  endtask

  function automatic in_item_t random_run();
    in_item_t rq;
    case ($urandom_range(9))
      0:       rq.run_length = 8'd0;
      1:       rq.run_length = 8'd255;
      2, 3, 4: rq.run_length = 8'($urandom_range(1, 8));
      default: rq.run_length = 8'($urandom_range(255));
    endcase
    case ($urandom_range(7))
      0:       rq.intensity = 8'd0;
      1:       rq.intensity = GradFullScale;
      default: rq.intensity = 8'($urandom_range(255));
    endcase
    return rq;
  endfunction

  function automatic logic [7:0] random_dim();
    case ($urandom_range(9))
      0:       return 8'd1;
      1:       return 8'd255;
      2:       return 8'd0;
      3:       return 8'($urandom_range(255));
      default: return 8'($urandom_range(1, 12));
    endcase
  endfunction

  function automatic logic [15:0] random_color();
    case ($urandom_range(5))
      0:       return 16'h0000;
      1:       return 16'hffff;
      default: return 16'($urandom_range(65535));
    endcase
  endfunction

  task automatic test_reset_state();
    // 1x1 image after reset: every nonzero run ends the image
    send_pair(8'd0, 8'd0);
    send_pair(8'd3, 8'd255);
  endtask

  task automatic test_blend_extremes();
    set_image(16'hffff, 16'h0000, 8'd255, 8'd255);
    send_pair(8'd1, 8'd0);
    send_pair(8'd1, 8'd1);
    send_pair(8'd1, 8'd127);
    send_pair(8'd1, 8'd128);
    send_pair(8'd1, 8'd255);
    // foreground below background: negative steps truncate toward zero
    set_image(16'h0000, 16'hffff, 8'd255, 8'd255);
    send_pair(8'd2, 8'd1);
    send_pair(8'd2, 8'd200);
    set_image(16'h1f80, 16'he007, 8'd255, 8'd255);
    send_pair(8'd255, 8'd254);
  endtask

  task automatic test_run_clamping();
    set_image(16'h34a2, 16'h0c51, 8'd4, 8'd3);
    send_pair(8'd5, 8'd90);
    send_pair(8'd0, 8'd170);
    send_pair(8'd7, 8'd10);
    send_pair(8'd255, 8'd33);
    send_pair(8'd12, 8'd240);
    send_pair(8'd1, 8'd64);
  endtask

  task automatic test_zero_dimension();
    set_image(16'haaaa, 16'h5555, 8'd0, 8'd3);
    send_pair(8'd2, 8'd100);
    send_pair(8'd2, 8'd100);
    set_image(16'h5555, 16'haaaa, 8'd0, 8'd0);
    send_pair(8'd0, 8'd50);
    send_pair(8'd9, 8'd50);
  endtask

  task automatic test_dimension_reload();
    set_image(16'h0f0f, 16'hf0f0, 8'd10, 8'd10);
    send_pair(8'd60, 8'd77);
    wait_drain();
    // a new width restarts the image mid-way
    cfg_write(REG_IMAGE_WIDTH, 32'd2);
    send_pair(8'd150, 8'd77);
    send_pair(8'd20, 8'd77);
  endtask

  task automatic test_backpressure();
    set_image(random_color(), random_color(), 8'd7, 8'd5);
    quiet = 1'b1;
    hold_requests++;
    repeat (40) send_run(random_run());
    quiet = 1'b0;
  endtask

  task automatic test_sender_pause();
    set_image(random_color(), random_color(), 8'd9, 8'd4);
    repeat (20) send_run(random_run());
    wait_drain();
    repeat (20) send_run(random_run());
  endtask

  task automatic test_random_images();
    for (int ph = 0; ph < 9; ph++) begin
      if (ph == 0) set_image(16'hffff, 16'hffff, 8'd255, 8'd255);
      else if (ph == 1) set_image(16'h0000, 16'h0000, 8'd1, 8'd1);
      else set_image(random_color(), random_color(), random_dim(), random_dim());
      quiet = (ph == 4);
      repeat (130) send_run(random_run());
      quiet = 1'b0;
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = 32'd0;
    in_valid_i = 1'b0;
    in_item_i = '0;
    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;
    repeat (2) @(negedge clk_i);

    test_reset_state();
    test_blend_extremes();
    test_run_clamping();
    test_zero_dimension();
    test_dimension_reload();
    test_backpressure();
    test_sender_pause();
    test_random_images();

    wait_drain();
    repeat (6) @(negedge clk_i);
    if (n_errors == 0) begin
      $display("rle_gradient_run_colorizer verification clean");
    end else begin
      $display("rle_gradient_run_colorizer verification failed");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("rle_gradient_run_colorizer verification failed");
    $finish;
  end

endmodule
